@@ design/helb_pkg.sv @@
// Shared types, codes and command/status structs for the line edit buffer.
`timescale 1ns / 1ps
package helb_pkg;

    localparam logic [7:0] KEY_HOME  = 8'h5B;
    localparam logic [7:0] KEY_END   = 8'h5D;
    localparam logic [7:0] KEY_UNDER = 8'h5F;

    typedef enum logic [1:0] {
        REQ_KEY   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_IGNORED = 2'd2,
        ST_END     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        KC_HOME,
        KC_END,
        KC_TEXT,
        KC_OTHER
    } t_kclass;

    typedef enum logic [1:0] {
        LS_CURSOR,
        LS_READ,
        LS_NXT,
        LS_FREE
    } t_lsel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_INS_RD,
        S_INS_LNK,
        S_INS_CUR,
        S_RD_ISSUE,
        S_RD_NEXT,
        S_RD_CHK,
        S_RD_DATA,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] key_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_char;
        logic       is_last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_in;
        logic    home;
        logic    go_end;
        logic    clear;
        logic    lk_rd;
        logic    lk_wr;
        t_lsel   lk_sel;
        logic    lk_wdata_free;
        logic    ins_link;
        logic    ins_commit;
        logic    ch_wr;
        logic    ch_rd;
        logic    save_nxt;
        logic    read_adv;
        logic    res_load;
        t_status res_status;
        logic    res_data;
        logic    out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] req;
        t_kclass    kclass;
        logic       full;
        logic       nxt_zero;
        logic       out_free;
    } t_stat;

endpackage

@@ design/helb_ctrl.sv @@
// Controller state machine that sequences each request through the datapath.
`timescale 1ns / 1ps
module helb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  helb_pkg::t_stat i_stat,
    output helb_pkg::t_cmd  o_cmd,
    output logic           o_in_stall
);

    helb_pkg::t_state r_state;
    helb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= helb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            helb_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = helb_pkg::S_DEC;
                end
            end
            helb_pkg::S_DEC: begin
                unique case (helb_pkg::t_req'(i_stat.req))
                    helb_pkg::REQ_KEY: begin
                        if (i_stat.kclass == helb_pkg::KC_TEXT && !i_stat.full) begin
                            n_state = helb_pkg::S_INS_RD;
                        end else begin
                            n_state = helb_pkg::S_RESP;
                        end
                    end
                    helb_pkg::REQ_READ: n_state = helb_pkg::S_RD_ISSUE;
                    default:            n_state = helb_pkg::S_RESP;
                endcase
            end
            helb_pkg::S_INS_RD:   n_state = helb_pkg::S_INS_LNK;
            helb_pkg::S_INS_LNK:  n_state = helb_pkg::S_INS_CUR;
            helb_pkg::S_INS_CUR:  n_state = helb_pkg::S_RESP;
            helb_pkg::S_RD_ISSUE: n_state = helb_pkg::S_RD_NEXT;
            helb_pkg::S_RD_NEXT:  n_state = helb_pkg::S_RD_CHK;
            helb_pkg::S_RD_CHK: begin
                if (i_stat.nxt_zero) begin
                    n_state = helb_pkg::S_RESP;
                end else begin
                    n_state = helb_pkg::S_RD_DATA;
                end
            end
            helb_pkg::S_RD_DATA:  n_state = helb_pkg::S_RESP;
            helb_pkg::S_RESP: begin
                if (i_stat.out_free) begin
                    n_state = helb_pkg::S_IDLE;
                end
            end
            default: n_state = helb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.res_status = helb_pkg::ST_DONE;
        o_cmd.lk_sel = helb_pkg::LS_CURSOR;
        o_in_stall = (r_state != helb_pkg::S_IDLE);
        unique case (r_state)
            helb_pkg::S_IDLE: begin
                o_cmd.load_in = i_in_valid;
            end
            helb_pkg::S_DEC: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_status = helb_pkg::ST_IGNORED;
                unique case (helb_pkg::t_req'(i_stat.req))
                    helb_pkg::REQ_KEY: begin
                        unique case (i_stat.kclass)
                            helb_pkg::KC_HOME: begin
                                o_cmd.home = 1'b1;
                                o_cmd.res_status = helb_pkg::ST_DONE;
                            end
                            helb_pkg::KC_END: begin
                                o_cmd.go_end = 1'b1;
                                o_cmd.res_status = helb_pkg::ST_DONE;
                            end
                            helb_pkg::KC_TEXT: begin
                                if (i_stat.full) begin
                                    o_cmd.res_status = helb_pkg::ST_FULL;
                                end else begin
                                    o_cmd.res_load = 1'b0;
                                end
                            end
                            default: o_cmd.res_status = helb_pkg::ST_IGNORED;
                        endcase
                    end
                    helb_pkg::REQ_READ: o_cmd.res_load = 1'b0;
                    helb_pkg::REQ_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        o_cmd.res_status = helb_pkg::ST_DONE;
                    end
                    default: o_cmd.res_status = helb_pkg::ST_IGNORED;
                endcase
            end
            helb_pkg::S_INS_RD: begin
                o_cmd.lk_rd = 1'b1;
                o_cmd.lk_sel = helb_pkg::LS_CURSOR;
                o_cmd.ch_wr = 1'b1;
            end
            helb_pkg::S_INS_LNK: begin
                o_cmd.lk_wr = 1'b1;
                o_cmd.lk_sel = helb_pkg::LS_FREE;
                o_cmd.ins_link = 1'b1;
            end
            helb_pkg::S_INS_CUR: begin
                o_cmd.lk_wr = 1'b1;
                o_cmd.lk_sel = helb_pkg::LS_CURSOR;
                o_cmd.lk_wdata_free = 1'b1;
                o_cmd.ins_commit = 1'b1;
                o_cmd.res_load = 1'b1;
                o_cmd.res_status = helb_pkg::ST_DONE;
            end
            helb_pkg::S_RD_ISSUE: begin
                o_cmd.lk_rd = 1'b1;
                o_cmd.lk_sel = helb_pkg::LS_READ;
            end
            helb_pkg::S_RD_NEXT: begin
                o_cmd.save_nxt = 1'b1;
            end
            helb_pkg::S_RD_CHK: begin
                if (i_stat.nxt_zero) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_status = helb_pkg::ST_END;
                end else begin
                    o_cmd.lk_rd = 1'b1;
                    o_cmd.lk_sel = helb_pkg::LS_NXT;
                    o_cmd.ch_rd = 1'b1;
                end
            end
            helb_pkg::S_RD_DATA: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_status = helb_pkg::ST_DONE;
                o_cmd.res_data = 1'b1;
                o_cmd.read_adv = 1'b1;
            end
            helb_pkg::S_RESP: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ design/helb_dp.sv @@
// Datapath: character and link memories, list pointers and the result register.
`timescale 1ns / 1ps
module helb_dp #(
    parameter int LINE_CAPACITY = 4095
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  helb_pkg::t_in_item  i_in,
    input  helb_pkg::t_cmd      i_cmd,
    input  logic                i_out_stall,
    output helb_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    output helb_pkg::t_out_item o_out
);

    localparam int DEPTH = LINE_CAPACITY + 1;
    localparam int NW = $clog2(DEPTH);
    localparam int FW = NW + 1;

    logic [7:0]    char_mem [DEPTH];
    logic [NW-1:0] link_mem [DEPTH];

    logic [1:0]    r_req;
    logic [7:0]    r_key;
    logic [NW-1:0] r_head;
    logic [NW-1:0] r_cursor;
    logic [NW-1:0] r_tail;
    logic [FW-1:0] r_free;
    logic [NW-1:0] r_read;
    logic [NW-1:0] r_nxt;
    logic [NW-1:0] r_lk_q;
    logic          r_lk_zero;
    logic [7:0]    r_ch_q;
    helb_pkg::t_out_item r_res;
    helb_pkg::t_out_item r_out;
    logic          r_out_valid;

    logic [NW-1:0] lk_addr;
    logic [NW-1:0] lk_wdata;
    logic [NW-1:0] link_val;
    logic [NW-1:0] free_node;
    logic          out_free;

    assign free_node = r_free[NW-1:0];
    // Node zero is the fixed head; its link lives in a register, not the memory.
    assign link_val  = r_lk_zero ? r_head : r_lk_q;
    assign lk_wdata  = i_cmd.lk_wdata_free ? free_node : link_val;
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        case (i_cmd.lk_sel)
            helb_pkg::LS_CURSOR: lk_addr = r_cursor;
            helb_pkg::LS_READ:   lk_addr = r_read;
            helb_pkg::LS_NXT:    lk_addr = r_nxt;
            default:             lk_addr = free_node;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lk_wr && lk_addr != '0) begin
            link_mem[lk_addr] <= lk_wdata;
        end
        if (i_cmd.lk_rd) begin
            r_lk_q    <= link_mem[lk_addr];
            r_lk_zero <= (lk_addr == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ch_wr) begin
            char_mem[free_node] <= r_key;
        end
        if (i_cmd.ch_rd) begin
            r_ch_q <= char_mem[r_nxt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req <= i_in.req_type;
            r_key <= i_in.key_byte;
        end
        if (i_cmd.save_nxt) begin
            r_nxt <= link_val;
        end
        if (i_cmd.res_load) begin
            r_res.status   <= i_cmd.res_status;
            r_res.out_char <= i_cmd.res_data ? r_ch_q : 8'd0;
            r_res.is_last  <= i_cmd.res_data ? (link_val == '0) : 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_cursor    <= '0;
            r_tail      <= '0;
            r_free      <= FW'(1);
            r_read      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_head   <= '0;
                r_cursor <= '0;
                r_tail   <= '0;
                r_free   <= FW'(1);
                r_read   <= '0;
            end
            if (i_cmd.home) begin
                r_cursor <= '0;
            end
            if (i_cmd.go_end) begin
                r_cursor <= r_tail;
            end
            // The new node becomes the tail when it inherits the end marker.
            if (i_cmd.ins_link && link_val == '0) begin
                r_tail <= free_node;
            end
            if (i_cmd.lk_wr && lk_addr == '0) begin
                r_head <= lk_wdata;
            end
            if (i_cmd.ins_commit) begin
                r_cursor <= free_node;
                r_free   <= r_free + FW'(1);
                r_read   <= '0;
            end
            if (i_cmd.read_adv) begin
                r_read <= r_nxt;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.req      = r_req;
        o_stat.full     = (r_free > FW'(LINE_CAPACITY));
        o_stat.nxt_zero = (r_nxt == '0);
        o_stat.out_free = out_free;
        if (r_key == helb_pkg::KEY_HOME) begin
            o_stat.kclass = helb_pkg::KC_HOME;
        end else if (r_key == helb_pkg::KEY_END) begin
            o_stat.kclass = helb_pkg::KC_END;
        end else if ((r_key >= 8'h41 && r_key <= 8'h5A) || (r_key >= 8'h61 && r_key <= 8'h7A)
                     || r_key == helb_pkg::KEY_UNDER) begin
            o_stat.kclass = helb_pkg::KC_TEXT;
        end else begin
            o_stat.kclass = helb_pkg::KC_OTHER;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ design/home_end_line_edit_buffer.sv @@
// Top level: line edit buffer with home/end cursor keys, held as a linked list.
// Each item takes one pass through a sequencer; a stalled result beat holds it in its result state.
// Cursor keys, ignored bytes, drops and clears go straight from decode to the result state.
// Inserts take one link read and two link writes before the result is loaded.
// Reads take two dependent link reads and a data read; past the end, the second link read is skipped.
// Reset is synchronous: the line is empty at once, with no memory clearing pass.
`timescale 1ns / 1ps
module home_end_line_edit_buffer #(
    parameter int LINE_CAPACITY = 4095
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  helb_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output helb_pkg::t_out_item o_out
);

    helb_pkg::t_cmd  cmd;
    helb_pkg::t_stat stat;

    helb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    helb_dp #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    // An accepted beat keeps the input side busy for the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted twice in a row");

    // The single link port never reads and writes in the same cycle.
    a_link_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.lk_rd && cmd.lk_wr))
        else $error("link memory read and write in one cycle");

    // A result is only loaded when the output register can take it.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("output register overwritten");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the home/end line edit buffer: directed and random traffic.
`timescale 1ns / 1ps
module testbench;

    localparam int LINE_CAPACITY = 4095;
    localparam int RANDOM_ITEMS  = 520;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    // Keeps its own copy of the linked-list line and predicts one result per request.
    class line_scoreboard;
        logic [7:0]  chars [0:LINE_CAPACITY];
        logic [11:0] links [0:LINE_CAPACITY];
        logic [11:0] cursor;
        logic [11:0] tail;
        logic [11:0] read_pos;
        logic [12:0] next_free;
        bit          reading;
        helb_pkg::t_out_item pending[$];
        int          errors;

        function new();
            errors = 0;
            start_line();
        endfunction

        function void start_line();
            links[0]  = '0;
            cursor    = '0;
            tail      = '0;
            next_free = 13'd1;
            read_pos  = '0;
            reading   = 1'b0;
        endfunction

        function bit is_text(logic [7:0] k);
            return (k >= "A" && k <= "Z") || (k >= "a" && k <= "z")
                || k == helb_pkg::KEY_UNDER;
        endfunction

        function void note_request(helb_pkg::t_in_item it);
            helb_pkg::t_out_item res;
            logic [11:0] fresh;
            logic [11:0] nxt;
            res = '0;
            res.status = helb_pkg::ST_IGNORED;
            case (it.req_type)
                helb_pkg::REQ_KEY: begin
                    if (it.key_byte == helb_pkg::KEY_HOME) begin
                        cursor = '0;
                        res.status = helb_pkg::ST_DONE;
                    end else if (it.key_byte == helb_pkg::KEY_END) begin
                        cursor = tail;
                        res.status = helb_pkg::ST_DONE;
                    end else if (is_text(it.key_byte)) begin
                        if (next_free > LINE_CAPACITY) begin
                            res.status = helb_pkg::ST_FULL;
                        end else begin
                            fresh = next_free[11:0];
                            chars[fresh] = it.key_byte;
                            links[fresh] = links[cursor];
                            links[cursor] = fresh;
                            cursor = fresh;
                            next_free = next_free + 13'd1;
                            if (links[fresh] == '0) tail = fresh;
                            // A successful insert sends the reader back to the line start.
                            read_pos = '0;
                            reading = 1'b0;
                            res.status = helb_pkg::ST_DONE;
                        end
                    end
                end
                helb_pkg::REQ_READ: begin
                    nxt = reading ? links[read_pos] : links[0];
                    if (nxt == '0) begin
                        res.status = helb_pkg::ST_END;
                    end else begin
                        res.out_char = chars[nxt];
                        res.is_last = (links[nxt] == '0);
                        read_pos = nxt;
                        reading = 1'b1;
                        res.status = helb_pkg::ST_DONE;
                    end
                end
                helb_pkg::REQ_CLEAR: begin
                    start_line();
                    res.status = helb_pkg::ST_DONE;
                end
                default: ;
            endcase
            pending.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(helb_pkg::t_out_item got);
            helb_pkg::t_out_item want;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected: status %0d", got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("status", 8'(want.status), 8'(got.status));
            compare_field("out_char", want.out_char, got.out_char);
            compare_field("is_last", 8'(want.is_last), 8'(got.is_last));
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    helb_pkg::t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    helb_pkg::t_out_item o_out;

    line_scoreboard line_check = new();
    bit quiet;
    int sent_count;
    int line_len;
    int cycle_count;

    home_end_line_edit_buffer #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("home_end_line_edit_buffer: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(0, 99) < 34);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) line_check.note_request(i_in);
            if (o_out_valid && !i_out_stall) line_check.check_result(o_out);
        end
    end

    task automatic send_req(logic [1:0] req, logic [7:0] key);
        helb_pkg::t_in_item it;
        it.req_type = req;
        it.key_byte = key;
        while (!quiet && $urandom_range(0, 99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_count++;
        if (req == helb_pkg::REQ_CLEAR) line_len = 0;
    endtask

    task automatic send_key(logic [7:0] key);
        send_req(helb_pkg::REQ_KEY, key);
    endtask

    task automatic send_read();
        send_req(helb_pkg::REQ_READ, 8'($urandom));
    endtask

    task automatic send_letter();
        int pick;
        pick = $urandom_range(0, 52);
        if (pick < 26) send_key(8'("A" + pick));
        else if (pick < 52) send_key(8'("a" + pick - 26));
        else send_key(helb_pkg::KEY_UNDER);
        if (line_len < LINE_CAPACITY) line_len++;
    endtask

    // One editing session: maybe a fresh line, some edits, then a run of reads with occasional letters.
    task automatic edit_session();
        int edits;
        int reads;
        int roll;
        if ($urandom_range(0, 99) < 20) send_req(helb_pkg::REQ_CLEAR, 8'($urandom));
        edits = $urandom_range(1, 12);
        repeat (edits) begin
            roll = $urandom_range(0, 99);
            if (roll < 68) send_letter();
            else if (roll < 80) send_key(helb_pkg::KEY_HOME);
            else if (roll < 92) send_key(helb_pkg::KEY_END);
            else if (roll < 96) send_key(8'($urandom));
            else send_req(REQ_SPARE, 8'($urandom));
        end
        reads = $urandom_range(1, line_len + 2);
        repeat (reads) begin
            if ($urandom_range(0, 99) < 6) send_letter();
            else send_read();
        end
    endtask

    initial begin
        int stop_at;
        quiet = 1'b0;
        sent_count = 0;
        line_len = 0;
        cycle_count = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in <= '0;
        i_out_stall <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty line, cursor keys, all text classes, ignored bytes and types.
        send_read();
        send_key(helb_pkg::KEY_END);
        send_key(helb_pkg::KEY_HOME);
        send_key("A");
        send_key("z");
        send_key(helb_pkg::KEY_UNDER);
        send_key("Z");
        send_key(helb_pkg::KEY_HOME);
        send_key("a");
        send_key(helb_pkg::KEY_END);
        send_key("m");
        send_read();
        send_read();
        send_key("Q");
        send_read();
        send_key(8'h00);
        send_key(8'hFF);
        send_key(8'h40);
        send_key(8'h7B);
        send_req(REQ_SPARE, 8'hA5);
        send_req(REQ_SPARE, 8'h5A);
        repeat (7) send_read();
        send_req(helb_pkg::REQ_CLEAR, 8'hFF);
        send_read();
        line_len = 0;

        // Random sessions with a stretch of back-to-back traffic in the middle.
        stop_at = sent_count + RANDOM_ITEMS;
        while (sent_count < stop_at) begin
            quiet = (stop_at - sent_count < 350) && (stop_at - sent_count >= 230);
            edit_session();
        end
        quiet = 1'b0;

        send_req(helb_pkg::REQ_CLEAR, 8'($urandom));
        send_letter();
        send_read();
        send_read();
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (line_check.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (line_check.errors == 0) begin
            $display("home_end_line_edit_buffer: match");
        end else begin
            $display("home_end_line_edit_buffer: mismatch");
        end
        $finish;
    end
endmodule
